/* rtl/core/fqb_pkg.sv */
// ----------------------------------------------------------------------------
// fqb_pkg: shared types and constants of the FASTQ record length binner
// Widths, character codes, record phases and result codes.
// ----------------------------------------------------------------------------
package fqb_pkg;

  // Longest sequence line that is accepted.
  localparam int unsigned MAX_READ_LENGTH = 1000;

  // Field widths of the channels and the configuration register.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 1;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned LENGTH_W = 10;
  localparam int unsigned LINE_W   = 32;
  localparam int unsigned FACTOR_W = 17;

  // The line length counter saturates at MAX_READ_LENGTH + 1.
  localparam int unsigned COUNT_W = $clog2(MAX_READ_LENGTH + 2);

  // Product of factor and read length, and the Q1.16 scaling.
  localparam int unsigned PROD_W = FACTOR_W + LENGTH_W;
  localparam int unsigned FRAC_W = 16;

  localparam logic [FACTOR_W-1:0] Q16_ONE       = FACTOR_W'(65536);
  localparam logic [FACTOR_W-1:0] FACTOR_RESET  = FACTOR_W'(32768);
  localparam logic [COUNT_W-1:0]  COUNT_MAX     = COUNT_W'(MAX_READ_LENGTH);

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;

  // Line of the four-line record.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SEQ    = 2'd1,
    PH_SEP    = 2'd2,
    PH_QUAL   = 2'd3
  } phase_t;

  // Kind of result.
  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 1'b0,
    KIND_ERROR  = 1'b1
  } kind_t;

  // Format error codes.
  typedef enum logic [CODE_W-1:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_HEADER   = 3'd1,
    ERR_EMPTY_READ   = 3'd2,
    ERR_READ_TOO_LONG = 3'd3,
    ERR_BAD_SEP      = 3'd4,
    ERR_QUAL_LENGTH  = 3'd5
  } err_t;

endpackage

/* rtl/core/fqb_text_if.sv */
// ----------------------------------------------------------------------------
// fqb_text_if: byte channel of FASTQ text
// Valid/ready channel carrying one text byte per transaction.
// ----------------------------------------------------------------------------
interface fqb_text_if;

  logic                        valid;
  logic                        ready;
  logic [fqb_pkg::BYTE_W-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);

endinterface

/* rtl/core/fqb_result_if.sv */
// ----------------------------------------------------------------------------
// fqb_result_if: result channel of the binner
// Valid/ready channel carrying one completed record or one format error.
// ----------------------------------------------------------------------------
interface fqb_result_if;

  logic                          valid;
  logic                          ready;
  logic [fqb_pkg::KIND_W-1:0]    result_kind;
  logic [fqb_pkg::CODE_W-1:0]    error_code;
  logic [fqb_pkg::LENGTH_W-1:0]  read_length;
  logic [fqb_pkg::LENGTH_W-1:0]  bucket_index;
  logic [fqb_pkg::LINE_W-1:0]    line_number;

  modport source (output valid, output result_kind, output error_code,
                  output read_length, output bucket_index, output line_number,
                  input ready);
  modport sink   (input valid, input result_kind, input error_code,
                  input read_length, input bucket_index, input line_number,
                  output ready);

endinterface

/* rtl/core/fastq_record_length_binner.sv */
// ----------------------------------------------------------------------------
// fastq_record_length_binner: FASTQ record checker and read length binner
// An accepted byte is held in the input register and parsed; its result is held in the result register.
// Throughput: one byte per cycle unless a full result register stalls; the state update of the parse stage sets it.
// Reset (rst, synchronous) returns to the header line, clears the counters
// and the halt, and sets the bucket factor to one half.
// ----------------------------------------------------------------------------
module fastq_record_length_binner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fqb_pkg::FACTOR_W-1:0]   cfg_wdata,
  fqb_text_if.sink                       text,
  fqb_result_if.source                   result
);

  import fqb_pkg::*;

  // Input register.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;

  // Parser state.
  phase_t             phase, phase_next;
  logic               at_line_start, at_line_start_next;
  logic [COUNT_W-1:0] line_length_count, line_length_count_next;
  logic [LENGTH_W-1:0] saved_read_length, saved_read_length_next;
  logic [LINE_W-1:0]  line_counter, line_counter_next;
  logic               halted, halted_next;
  logic [FACTOR_W-1:0] bucket_factor;

  // Result produced by the current byte.
  logic                res_load;
  kind_t               res_kind;
  err_t                res_code;
  logic [LENGTH_W-1:0] res_length;
  logic [LENGTH_W-1:0] res_bucket;

  logic                advance;
  logic                s1_fire;
  logic                is_newline;
  logic [COUNT_W-1:0]  base_count;
  logic [PROD_W-1:0]   product;

  // The parse stage moves when the result register is free or being emptied.
  assign advance    = !result.valid || result.ready;
  assign text.ready = advance || !s1_valid;
  assign s1_fire    = s1_valid && advance && !halted;
  assign is_newline = (s1_byte == CH_NEWLINE);
  assign base_count = at_line_start ? '0 : line_length_count;
  assign product    = PROD_W'(bucket_factor) * PROD_W'(saved_read_length);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.text_byte;
    end
  end

  // Bucket factor register, saturated to 1.0.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_factor <= FACTOR_RESET;
    end else if (cfg_we) begin
      bucket_factor <= (cfg_wdata > Q16_ONE) ? Q16_ONE : cfg_wdata;
    end
  end

  // Record parsing of one byte.
  always_comb begin
    phase_next             = phase;
    at_line_start_next     = at_line_start;
    line_length_count_next = line_length_count;
    saved_read_length_next = saved_read_length;
    line_counter_next      = line_counter;
    halted_next            = halted;
    res_load               = 1'b0;
    res_kind               = KIND_RECORD;
    res_code               = ERR_NONE;
    res_length             = '0;
    res_bucket             = '0;

    if (s1_fire) begin
      if (at_line_start) begin
        line_counter_next  = line_counter + LINE_W'(1);
        at_line_start_next = 1'b0;
      end
      line_length_count_next = base_count;

      // The first byte of a header or separator line is checked at once.
      if (at_line_start && phase == PH_HEADER && s1_byte != CH_AT) begin
        res_load = 1'b1;
        res_kind = KIND_ERROR;
        res_code = ERR_BAD_HEADER;
      end else if (at_line_start && phase == PH_SEP && s1_byte != CH_PLUS) begin
        res_load = 1'b1;
        res_kind = KIND_ERROR;
        res_code = ERR_BAD_SEP;
      end else if (!is_newline) begin
        if (base_count <= COUNT_MAX) begin
          line_length_count_next = base_count + COUNT_W'(1);
        end
      end else begin
        at_line_start_next = 1'b1;
        unique case (phase)
          PH_HEADER: begin
            phase_next = PH_SEQ;
          end
          PH_SEQ: begin
            if (base_count > COUNT_MAX) begin
              res_load = 1'b1;
              res_kind = KIND_ERROR;
              res_code = ERR_READ_TOO_LONG;
            end else if (base_count == '0) begin
              res_load = 1'b1;
              res_kind = KIND_ERROR;
              res_code = ERR_EMPTY_READ;
            end else begin
              saved_read_length_next = base_count[LENGTH_W-1:0];
              phase_next             = PH_SEP;
            end
          end
          PH_SEP: begin
            phase_next = PH_QUAL;
          end
          PH_QUAL: begin
            if (base_count != COUNT_W'(saved_read_length)) begin
              res_load = 1'b1;
              res_kind = KIND_ERROR;
              res_code = ERR_QUAL_LENGTH;
            end else begin
              res_load   = 1'b1;
              res_length = saved_read_length;
              res_bucket = product[FRAC_W +: LENGTH_W];
              phase_next = PH_HEADER;
            end
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end

      // Any error stops the parser until reset.
      if (res_load && res_kind == KIND_ERROR) begin
        halted_next = 1'b1;
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      at_line_start     <= 1'b1;
      line_length_count <= '0;
      saved_read_length <= '0;
      line_counter      <= '0;
      halted            <= 1'b0;
    end else begin
      phase             <= phase_next;
      at_line_start     <= at_line_start_next;
      line_length_count <= line_length_count_next;
      saved_read_length <= saved_read_length_next;
      line_counter      <= line_counter_next;
      halted            <= halted_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_load) begin
      result.result_kind  <= res_kind;
      result.error_code   <= res_code;
      result.read_length  <= res_length;
      result.bucket_index <= res_bucket;
      result.line_number  <= line_counter_next;
    end
  end

`ifndef ASSERT_OFF
  // An error transaction always halts the parser.
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (res_load && res_kind == KIND_ERROR) |=> halted)
    else $error("error result did not halt the parser");

  // Once halted, no further result is produced.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    halted |-> !res_load)
    else $error("result produced while halted");

  // A completed record carries no error code and a non-empty read.
  a_record_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.result_kind == KIND_RECORD) |->
      (result.error_code == ERR_NONE && result.read_length != '0))
    else $error("record result with error code or empty read");

  // The line length counter never passes its saturation point.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_length_count <= COUNT_MAX + COUNT_W'(1))
    else $error("line length counter beyond saturation");
`endif

endmodule

/* bench/tb_fastq_record_length_binner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fastq_record_length_binner: self-checking bench of the FASTQ binner
// Streams FASTQ text through the byte channel under varied back-pressure and
// checks every record length, bucket and format error against a predictor.
// ----------------------------------------------------------------------------
module tb_fastq_record_length_binner;

  import fqb_pkg::*;

  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 12;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASE_BYTES    = 170;
  localparam int unsigned FACTOR_ALL_ONE = (1 << FACTOR_W) - 1;

  // Predicts the result stream of the binner and checks what comes out.
  class record_outcome_tracker;

    typedef struct {
      kind_t                kind;
      err_t                 code;
      logic [LENGTH_W-1:0]  length;
      logic [LENGTH_W-1:0]  bucket;
      logic [LINE_W-1:0]    line;
    } outcome_t;

    logic [FACTOR_W-1:0]  factor;
    phase_t               phase;
    bit                   line_start;
    logic [10:0]          line_len;
    logic [LENGTH_W-1:0]  saved_len;
    logic [LINE_W-1:0]    line_no;
    bit                   halted;
    outcome_t             pending_outcomes[$];
    int unsigned          mismatches;

    function new();
      factor     = FACTOR_RESET;
      phase      = PH_HEADER;
      line_start = 1'b1;
      line_len   = '0;
      saved_len  = '0;
      line_no    = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    // Factors above one are clipped to one.
    function void set_factor(logic [FACTOR_W-1:0] value);
      factor = (value > Q16_ONE) ? Q16_ONE : value;
    endfunction

    function int unsigned pending();
      return pending_outcomes.size();
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void push_outcome(kind_t kind, err_t code, logic [LENGTH_W-1:0] length,
                               logic [LENGTH_W-1:0] bucket);
      outcome_t o;
      o.kind   = kind;
      o.code   = code;
      o.length = length;
      o.bucket = bucket;
      o.line   = line_no;
      pending_outcomes.push_back(o);
      if (kind == KIND_ERROR) begin
        halted = 1'b1;
      end
    endfunction

    // Advances the record state by one accepted text byte.
    function void note_text_byte(logic [BYTE_W-1:0] b);
      logic [PROD_W-1:0] prod;
      if (halted) begin
        return;
      end
      // The first byte of a line opens it and is checked in header and separator lines.
      if (line_start) begin
        line_no    = line_no + 1;
        line_len   = '0;
        line_start = 1'b0;
        if (phase == PH_HEADER && b != CH_AT) begin
          push_outcome(KIND_ERROR, ERR_BAD_HEADER, '0, '0);
          return;
        end
        if (phase == PH_SEP && b != CH_PLUS) begin
          push_outcome(KIND_ERROR, ERR_BAD_SEP, '0, '0);
          return;
        end
      end
      // Ordinary bytes only count, saturating just above the longest read.
      if (b != CH_NEWLINE) begin
        if (line_len <= MAX_READ_LENGTH) begin
          line_len = line_len + 1;
        end
        return;
      end
      // A newline closes the line and moves on to the next one of the record.
      line_start = 1'b1;
      case (phase)
        PH_HEADER: begin
          phase = PH_SEQ;
        end
        PH_SEQ: begin
          if (line_len > MAX_READ_LENGTH) begin
            push_outcome(KIND_ERROR, ERR_READ_TOO_LONG, '0, '0);
          end else if (line_len == 0) begin
            push_outcome(KIND_ERROR, ERR_EMPTY_READ, '0, '0);
          end else begin
            saved_len = line_len[LENGTH_W-1:0];
            phase     = PH_SEP;
          end
        end
        PH_SEP: begin
          phase = PH_QUAL;
        end
        default: begin
          if (line_len != {1'b0, saved_len}) begin
            push_outcome(KIND_ERROR, ERR_QUAL_LENGTH, '0, '0);
          end else begin
            prod = factor * saved_len;
            push_outcome(KIND_RECORD, ERR_NONE, saved_len, prod[FRAC_W +: LENGTH_W]);
            phase = PH_HEADER;
          end
        end
      endcase
    endfunction

    task check_outcome(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                       logic [LENGTH_W-1:0] length, logic [LENGTH_W-1:0] bucket,
                       logic [LINE_W-1:0] line);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        flag_mismatch($sformatf("result with none due: kind %0d code %0d line %0d",
                                kind, code, line));
        return;
      end
      want = pending_outcomes.pop_front();
      if (kind !== want.kind || code !== want.code || length !== want.length ||
          bucket !== want.bucket || line !== want.line) begin
        flag_mismatch($sformatf(
          "got kind %0d code %0d len %0d bucket %0d line %0d, due %0d %0d %0d %0d %0d",
          kind, code, length, bucket, line,
          want.kind, want.code, want.length, want.bucket, want.line));
      end
    endtask

  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [FACTOR_W-1:0]   cfg_wdata;

  fqb_text_if   text_ch ();
  fqb_result_if result_ch ();

  record_outcome_tracker tracker = new();

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned stall_now;
  int unsigned hold_left;
  bit          hold_req;
  int unsigned bytes_taken;
  int unsigned quiet_cycles;

  fastq_record_length_binner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .text      (text_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    result_ch.ready = 1'b0;
    hold_left       = 0;
    stall_now       = 0;
    forever begin
      @(posedge clk);
      stall_now = snk_stall_pct;
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_now);
      end
    end
  end

  // Monitor: feeds accepted bytes to the predictor, checks each result
  // transaction, and ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (text_ch.valid && text_ch.ready) begin
      tracker.note_text_byte(text_ch.text_byte);
      bytes_taken++;
    end
    if (result_ch.valid && result_ch.ready) begin
      tracker.check_outcome(result_ch.result_kind, result_ch.error_code,
                            result_ch.read_length, result_ch.bucket_index,
                            result_ch.line_number);
    end
    if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one byte and returns at the falling edge after it is taken.
  task automatic send_byte(input logic [BYTE_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid     <= 1'b1;
    text_ch.text_byte <= value;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
  endtask

  // Line content: any byte but a newline, with the record marks favoured.
  task automatic send_filler(input int unsigned count);
    int unsigned b;
    repeat (count) begin
      case ($urandom_range(7))
        0:       b = CH_AT;
        1:       b = CH_PLUS;
        default: begin
          do b = $urandom_range(255); while (b == CH_NEWLINE);
        end
      endcase
      send_byte(BYTE_W'(b));
    end
  endtask

  task automatic send_record(input int unsigned seq_len, input int unsigned qual_len,
                             input int unsigned hdr_len, input int unsigned sep_len);
    send_byte(CH_AT);
    send_filler(hdr_len);
    send_byte(CH_NEWLINE);
    send_filler(seq_len);
    send_byte(CH_NEWLINE);
    send_byte(CH_PLUS);
    send_filler(sep_len);
    send_byte(CH_NEWLINE);
    send_filler(qual_len);
    send_byte(CH_NEWLINE);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_factor(input logic [FACTOR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    tracker.set_factor(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned mark;
    int unsigned seq_len;
    int unsigned qual_len;
    int unsigned b;
    err_t        fault;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    hold_req          = 1'b0;
    bytes_taken       = 0;
    quiet_cycles      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: shortest lines at the reset factor, then the longest read
    // and the factor extremes, including a write that must be clipped.
    send_record(1, 1, 0, 0);
    send_record(4, 4, 3, 2);
    drain_results();
    write_factor(Q16_ONE);
    send_record(MAX_READ_LENGTH, MAX_READ_LENGTH, 1, 0);
    drain_results();
    write_factor(FACTOR_W'(FACTOR_ALL_ONE));
    send_record(9, 9, 1, 1);
    drain_results();
    write_factor('0);
    send_record(6, 6, 0, 0);
    drain_results();
    write_factor(FACTOR_W'(1));
    send_record(12, 12, 2, 1);

    // Random part: well-formed records with random content, cycling through
    // the idling patterns, each with a fresh factor.
    for (int p = 0; p < 8; p++) begin
      drain_results();
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 78; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 78; end
        default: begin src_idle_pct = 14; snk_stall_pct = 14; end
      endcase
      if (p == 0) begin
        write_factor(FACTOR_W'(Q16_ONE - 1));
      end else if ($urandom_range(3) == 0) begin
        write_factor(FACTOR_W'($urandom_range(FACTOR_ALL_ONE)));
      end else begin
        write_factor(FACTOR_W'($urandom_range(Q16_ONE)));
      end

      // Receiver holds off while short records keep coming, so the block
      // fills up and has to stall its input.
      if (p == 0) begin
        hold_req = 1'b1;
        repeat (24) send_record(1, 1, 0, 0);
      end

      // Sender stops in the middle of a sequence line until all results are
      // in; the unfinished line must not produce anything.
      if (p == 4) begin
        send_byte(CH_AT);
        send_filler(4);
        send_byte(CH_NEWLINE);
        send_filler(5);
        drain_results();
        send_byte(CH_NEWLINE);
        send_byte(CH_PLUS);
        send_byte(CH_NEWLINE);
        send_filler(5);
        send_byte(CH_NEWLINE);
      end

      mark = bytes_taken;
      while (bytes_taken - mark < PHASE_BYTES) begin
        seq_len = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
        send_record(seq_len, seq_len, $urandom_range(10), $urandom_range(3));
      end
    end

    // One format error ends all parsing, so a single one closes the run.
    drain_results();
    src_idle_pct  = 14;
    snk_stall_pct = 14;
    fault = err_t'($urandom_range(ERR_BAD_HEADER, ERR_QUAL_LENGTH));
    case (fault)
      ERR_BAD_HEADER: begin
        do b = $urandom_range(255); while (b == CH_AT);
        send_byte(BYTE_W'(b));
        send_filler(3);
        send_byte(CH_NEWLINE);
      end
      ERR_EMPTY_READ: begin
        send_record(0, 0, 2, 0);
      end
      ERR_READ_TOO_LONG: begin
        send_record(MAX_READ_LENGTH + 1 + $urandom_range(40), 3, 1, 0);
      end
      ERR_BAD_SEP: begin
        send_byte(CH_AT);
        send_byte(CH_NEWLINE);
        send_filler(4);
        send_byte(CH_NEWLINE);
        do b = $urandom_range(255); while (b == CH_PLUS);
        send_byte(BYTE_W'(b));
        send_byte(CH_NEWLINE);
      end
      ERR_QUAL_LENGTH: begin
        seq_len = $urandom_range(1, 12);
        do qual_len = $urandom_range(24); while (qual_len == seq_len);
        send_record(seq_len, qual_len, 1, 1);
      end
      default: begin
        send_record(1, 2, 0, 0);
      end
    endcase
    // A well-formed record after the error must be swallowed silently.
    send_record(5, 5, 1, 1);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fqb_pkg.sv
rtl/core/fqb_text_if.sv
rtl/core/fqb_result_if.sv
rtl/core/fastq_record_length_binner.sv
bench/tb_fastq_record_length_binner.sv
